// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SUD_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("sud: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SUD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("sud: next-cycle check failed");

`endif

// File: rtl/core/sud_pkg.sv
// Shared types and constants of the signed/unsigned divider.
package sud_pkg;

  localparam int FIELD_W = 32;

  localparam logic OPC_UNSIGNED = 1'b0;
  localparam logic OPC_SIGNED   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FIXUP
  } sud_state_t;

  typedef struct packed {
    logic load;
    logic step;
  } sud_ctrl_t;

endpackage

// File: rtl/core/sud_if.sv
// Handshake channels of the divider: operand words in, result words out.
interface sud_in_if import sud_pkg::*;;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [FIELD_W-1:0] dividend;
  logic [FIELD_W-1:0] divisor;

  modport source (output valid, output opcode, output dividend, output divisor,
                  input ready);
  modport sink   (input valid, input opcode, input dividend, input divisor,
                  output ready);
endinterface

interface sud_out_if import sud_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] quotient;
  logic [FIELD_W-1:0] remainder;
  logic               divide_by_zero;

  modport source (output valid, output quotient, output remainder,
                  output divide_by_zero, input ready);
  modport sink   (input valid, input quotient, input remainder,
                  input divide_by_zero, output ready);
endinterface

// File: rtl/core/signed_unsigned_divider_core.sv
// Top level of the signed/unsigned integer divider.
//
// Divides a dividend word by a divisor word, unsigned (opcode 0) or two's
// complement signed (opcode 1), with truncation toward zero: the quotient
// takes the XOR of the operand signs and the remainder the dividend's sign.
// Operands are taken as DATA_WIDTH-bit values (truncated or zero-extended
// from the 32-bit fields) and results are returned the same way. A zero
// divisor returns quotient 0, remainder all-ones (1 for a negative signed
// dividend) and raises divide_by_zero. One word is in flight at a time: the
// shift-subtract unit retires one quotient bit per cycle through a load step
// with operand sign handling, DATA_WIDTH divide steps and a sign fix-up step
// that waits for the output register to be free or drained. The result sits
// in an output register, so the next word is accepted while the previous
// result waits.
module signed_unsigned_divider_core import sud_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  sud_in_if.sink    in_ch,
  sud_out_if.source out_ch
);

  localparam int W     = DATA_WIDTH;
  localparam int CNT_W = $clog2(DATA_WIDTH);

  sud_state_t state_r, state_nxt;
  sud_ctrl_t  ctrl;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             last_step;
  logic             out_load;

  // Operand decode on the accept cycle.
  logic         is_sgn;
  logic [W-1:0] a_raw, b_raw, a_mag, b_mag;
  logic         a_neg, b_neg, a_zero, b_zero, neg_q;

  // Sign fix-up flags held for the word in flight.
  logic neg_q_r, neg_r_r, dz_r;

  logic [W-1:0] core_quo, core_rem;
  logic [W-1:0] q_sel, r_sel, q_fin, r_fin;

  logic               out_valid_r;
  logic [FIELD_W-1:0] out_quo_r, out_rem_r;
  logic               out_dz_r;

  // ---------------------------------------------------------------------
  // Operand decode: take magnitudes and work out which results to negate.
  // ---------------------------------------------------------------------
  always_comb begin
    case (in_ch.opcode)
      OPC_UNSIGNED: is_sgn = 1'b0;
      OPC_SIGNED:   is_sgn = 1'b1;
      default:      is_sgn = 1'b0;
    endcase
  end

  assign a_raw  = W'(in_ch.dividend);
  assign b_raw  = W'(in_ch.divisor);
  assign a_neg  = is_sgn & a_raw[W-1];
  assign b_neg  = is_sgn & b_raw[W-1];
  assign a_zero = (a_raw == '0);
  assign b_zero = (b_raw == '0);
  // Negate the quotient only for a real sign mismatch; a zero divisor keeps
  // quotient 0 and a zero dividend needs no negation.
  assign neg_q  = (a_neg & ~b_neg & ~b_zero) | (~a_neg & ~a_zero & b_neg);
  assign a_mag  = a_neg ? (W'(0) - a_raw) : a_raw;
  assign b_mag  = b_neg ? (W'(0) - b_raw) : b_raw;

  // ---------------------------------------------------------------------
  // Sequencer: load, DATA_WIDTH steps, fix-up into the output register.
  // ---------------------------------------------------------------------
  assign last_step = (cnt_r == '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_DIVIDE;
      ST_DIVIDE: if (last_step)   state_nxt = ST_FIXUP;
      ST_FIXUP:  if (out_load)    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    ctrl.load   = 1'b0;
    ctrl.step   = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        ctrl.load   = in_ch.valid;
      end
      ST_DIVIDE: begin
        ctrl.step = 1'b1;
      end
      ST_FIXUP: begin
        // Hand over once the output register is free or being drained.
        out_load = ~out_valid_r | out_ch.ready;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.load) begin
      cnt_nxt = CNT_W'(DATA_WIDTH - 1);
    end else if (ctrl.step) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Hold the fix-up flags for the word in flight.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      neg_q_r <= neg_q;
      neg_r_r <= a_neg;
      dz_r    <= b_zero;
    end
  end

  sud_shift_div #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_shift_div (
    .clk  (clk),
    .ctrl (ctrl),
    .num  (a_mag),
    .den  (b_mag),
    .quo  (core_quo),
    .rem  (core_rem)
  );

  // ---------------------------------------------------------------------
  // Fix-up: substitute the divide-by-zero values, then apply the signs.
  // ---------------------------------------------------------------------
  assign q_sel = dz_r ? '0 : core_quo;
  assign r_sel = dz_r ? '1 : core_rem;
  assign q_fin = neg_q_r ? (W'(0) - q_sel) : q_sel;
  assign r_fin = neg_r_r ? (W'(0) - r_sel) : r_sel;

  // Output register: load on hand-over, drop once the word is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_quo_r <= FIELD_W'(q_fin);
      out_rem_r <= FIELD_W'(r_fin);
      out_dz_r  <= dz_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.quotient       = out_quo_r;
  assign out_ch.remainder      = out_rem_r;
  assign out_ch.divide_by_zero = out_dz_r;

endmodule

// File: rtl/core/sud_shift_div.sv
// Restoring shift-subtract unit: one quotient bit per step, MSB first.
module sud_shift_div import sud_pkg::*; #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  sud_ctrl_t             ctrl,
  input  logic [DATA_WIDTH-1:0] num,
  input  logic [DATA_WIDTH-1:0] den,
  output logic [DATA_WIDTH-1:0] quo,
  output logic [DATA_WIDTH-1:0] rem
);

  localparam int W = DATA_WIDTH;

  // Dividend bits leave at the top while quotient bits enter at the bottom.
  logic [W-1:0] nq_r, nq_nxt;
  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] den_r, den_nxt;
  logic [W:0]   partial;
  logic [W+1:0] diff;
  logic         qbit;

  assign partial = {rem_r, nq_r[W-1]};
  assign diff    = {1'b0, partial} - {2'b00, den_r};
  assign qbit    = ~diff[W+1];

  always_comb begin
    nq_nxt  = nq_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    if (ctrl.load) begin
      nq_nxt  = num;
      rem_nxt = '0;
      den_nxt = den;
    end else if (ctrl.step) begin
      nq_nxt  = {nq_r[W-2:0], qbit};
      rem_nxt = qbit ? diff[W-1:0] : partial[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    nq_r  <= nq_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quo = nq_r;
  assign rem = rem_r;

endmodule

// File: rtl/core/sud_checker.sv
// Port-level checks of the divider, bound to its top level.
`include "assert_macros.svh"

module sud_checker import sud_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FIELD_W-1:0] out_quotient,
  input logic [FIELD_W-1:0] out_remainder,
  input logic               out_divide_by_zero
);

  `SUD_ASSERT_NEXT(a_out_valid_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `SUD_ASSERT_NEXT(a_out_word_hold, clk, rst_n, out_valid && !out_ready, $stable(out_quotient) && $stable(out_remainder) && $stable(out_divide_by_zero))
  `SUD_ASSERT_NEXT(a_one_word_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
  `SUD_ASSERT_NOW(a_dbz_zero_quotient, clk, rst_n, out_valid && out_divide_by_zero, out_quotient == '0)

endmodule

bind signed_unsigned_divider_core sud_checker u_sud_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_quotient       (out_ch.quotient),
  .out_remainder      (out_ch.remainder),
  .out_divide_by_zero (out_ch.divide_by_zero)
);

// File: verif/signed_unsigned_divider_core_tb.sv
// Testbench for the signed/unsigned divider: directed corners, random words, self-checking.
`timescale 1ns / 100ps

module signed_unsigned_divider_core_tb import sud_pkg::*;;

  // One word of operands, with the idle time the sender inserts ahead of it.
  typedef struct {
    logic               opcode;
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
    int                 idle;
    bit                 wait_empty;
  } div_job_t;

  typedef struct packed {
    logic [FIELD_W-1:0] quotient;
    logic [FIELD_W-1:0] remainder;
    logic               divide_by_zero;
  } div_result_t;

  localparam int RANDOM_WORDS = 1650;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n;

  sud_in_if  in_ch ();
  sud_out_if out_ch ();

  signed_unsigned_divider_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  div_job_t    job_q[$];
  div_result_t quot_rem_q[$];

  int words_sent;
  int words_rcvd;
  int mismatches;
  int directed_cnt;
  int random_cnt;
  int signed_cnt;
  int zero_div_cnt;
  int holds_done;
  bit rx_hold_on;

  // Sender state, private to the driver process.
  int idle_cnt;
  bit idle_loaded;

  // Receiver state, private to the monitor process.
  int stall_left;
  int long_left;

  always #10 clk = ~clk;

  // Expected quotient/remainder: divide magnitudes, then restore the signs the
  // way C truncating division does.
  function automatic div_result_t divide_expect(logic opcode, logic [FIELD_W-1:0] dividend,
                                                logic [FIELD_W-1:0] divisor);
    div_result_t        res;
    logic [FIELD_W-1:0] num_mag;
    logic [FIELD_W-1:0] den_mag;
    logic               flip_q;
    logic               flip_r;
    num_mag = dividend;
    den_mag = divisor;
    flip_q  = 1'b0;
    flip_r  = 1'b0;
    if (opcode == OPC_SIGNED) begin
      // A zero operand never flips the quotient sign.
      flip_q = (dividend[FIELD_W-1] != divisor[FIELD_W-1]) && (dividend != '0) &&
               (divisor != '0);
      flip_r = dividend[FIELD_W-1];
      if (dividend[FIELD_W-1]) num_mag = '0 - dividend;
      if (divisor[FIELD_W-1])  den_mag = '0 - divisor;
    end
    res.divide_by_zero = (den_mag == '0);
    if (res.divide_by_zero) begin
      res.quotient  = '0;
      res.remainder = '1;
    end else begin
      res.quotient  = num_mag / den_mag;
      res.remainder = num_mag % den_mag;
    end
    if (flip_q) res.quotient  = '0 - res.quotient;
    if (flip_r) res.remainder = '0 - res.remainder;
    return res;
  endfunction

  // Idle length: mostly none or short, a few long enough to span a whole divide.
  function automatic int pick_idle(bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 5);
    if (roll < 96) return $urandom_range(6, 40);
    return $urandom_range(60, 150);
  endfunction

  // Operand pattern: full range, small, corner values, small negative, or varied magnitude.
  function automatic logic [FIELD_W-1:0] pick_operand();
    logic [FIELD_W-1:0] corners[5];
    int                 roll;
    corners = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    roll = $urandom_range(0, 9);
    if (roll < 3) return $urandom();
    if (roll < 5) return $urandom_range(0, 255);
    if (roll < 6) return corners[$urandom_range(0, 4)];
    if (roll < 7) return '0 - $urandom_range(1, 255);
    return $urandom() >> $urandom_range(0, 31);
  endfunction

  function automatic void add_job(logic opcode, logic [FIELD_W-1:0] dividend,
                                  logic [FIELD_W-1:0] divisor, int idle, bit wait_empty);
    div_job_t job;
    job.opcode     = opcode;
    job.dividend   = dividend;
    job.divisor    = divisor;
    job.idle       = idle;
    job.wait_empty = wait_empty;
    job_q.push_back(job);
    if (opcode == OPC_SIGNED) signed_cnt++;
    if (divisor == '0) zero_div_cnt++;
  endfunction

  // Driver: hold a word until it is taken, then advance through the job queue,
  // idling between words as each job asks.
  always @(posedge clk) begin
    div_job_t job;
    int       sent_now;
    logic     drive;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      words_sent  <= 0;
      idle_cnt    = 0;
      idle_loaded = 0;
    end else begin
      sent_now = words_sent;
      if (in_ch.valid && in_ch.ready) begin
        quot_rem_q.push_back(divide_expect(in_ch.opcode, in_ch.dividend, in_ch.divisor));
        sent_now++;
      end
      words_sent <= sent_now;
      drive = in_ch.valid && !in_ch.ready;
      if (!drive && job_q.size() != 0) begin
        if (!idle_loaded) begin
          idle_cnt    = job_q[0].idle;
          idle_loaded = 1;
        end
        // Keep offering words while the receiver is held off, so the block backs up.
        if (rx_hold_on) idle_cnt = 0;
        if (idle_cnt > 0) begin
          idle_cnt--;
        end else if (job_q[0].wait_empty && sent_now != words_rcvd) begin
          // Pause until every result already owed has come back.
        end else begin
          job = job_q.pop_front();
          in_ch.opcode   <= job.opcode;
          in_ch.dividend <= job.dividend;
          in_ch.divisor  <= job.divisor;
          idle_loaded    = 0;
          drive          = 1'b1;
        end
      end
      in_ch.valid <= drive;
    end
  end

  // Monitor: check each result against the oldest expectation, and stall the
  // result channel at random, with calm stretches and two long hold-offs.
  always @(posedge clk) begin
    div_result_t want;
    logic        take;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_hold_on   <= 1'b0;
      words_rcvd   <= 0;
      stall_left   = 0;
      long_left    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        words_rcvd <= words_rcvd + 1;
        if (quot_rem_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: q %h r %h dz %b", out_ch.quotient,
                     out_ch.remainder, out_ch.divide_by_zero);
        end else begin
          want = quot_rem_q.pop_front();
          if (out_ch.quotient !== want.quotient || out_ch.remainder !== want.remainder ||
              out_ch.divide_by_zero !== want.divide_by_zero) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch on word %0d: expected q %h r %h dz %b, got q %h r %h dz %b",
                       words_rcvd, want.quotient, want.remainder, want.divide_by_zero,
                       out_ch.quotient, out_ch.remainder, out_ch.divide_by_zero);
          end
        end
      end
      take = 1'b1;
      if (long_left > 0) begin
        long_left--;
        take = 1'b0;
      end else if (holds_done < 2 && words_rcvd >= (holds_done == 0 ? 300 : 1100)) begin
        long_left = LONG_HOLD - 1;
        holds_done++;
        take = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else if ((words_rcvd / 120) % 3 != 0 && $urandom_range(0, 5) == 0) begin
        stall_left = pick_idle(0);
        take = (stall_left == 0);
      end
      out_ch.ready <= take;
      rx_hold_on   <= (long_left > 0);
    end
  end

  // Watchdog: end a hung run.
  initial begin
    #60_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    bit calm;
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OPC_UNSIGNED;
    in_ch.dividend  = '0;
    in_ch.divisor   = '0;
    out_ch.ready    = 1'b0;
    mismatches      = 0;
    holds_done      = 0;

    // Directed corners: unsigned extremes, divide by zero in both modes,
    // zero dividend, most negative dividend, and every sign combination.
    add_job(OPC_UNSIGNED, 32'h0000_0000, 32'h0000_0001, 0, 0);
    add_job(OPC_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0);
    add_job(OPC_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
    add_job(OPC_UNSIGNED, 32'h0000_0007, 32'h0000_0000, 0, 0);
    add_job(OPC_UNSIGNED, 32'h0000_0000, 32'h0000_0000, 0, 0);
    add_job(OPC_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0000, 0, 0);
    add_job(OPC_UNSIGNED, 32'h1234_5678, 32'h0000_000A, 0, 0);
    add_job(OPC_UNSIGNED, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0);
    add_job(OPC_UNSIGNED, 32'h8000_0000, 32'h0000_0003, 0, 0);
    add_job(OPC_SIGNED,   32'hFFFF_FFF9, 32'h0000_0002, 0, 0);
    add_job(OPC_SIGNED,   32'h0000_0007, 32'hFFFF_FFFE, 0, 0);
    add_job(OPC_SIGNED,   32'hFFFF_FFF9, 32'hFFFF_FFFE, 0, 0);
    add_job(OPC_SIGNED,   32'h0000_0000, 32'hFFFF_FFFB, 0, 0);
    add_job(OPC_SIGNED,   32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
    add_job(OPC_SIGNED,   32'h8000_0000, 32'h0000_0001, 0, 0);
    add_job(OPC_SIGNED,   32'hFFFF_FFFB, 32'h0000_0000, 0, 0);
    add_job(OPC_SIGNED,   32'h0000_0005, 32'h0000_0000, 0, 0);
    add_job(OPC_SIGNED,   32'h0000_0000, 32'h0000_0000, 0, 0);
    add_job(OPC_SIGNED,   32'h8000_0000, 32'h0000_0000, 0, 0);
    add_job(OPC_SIGNED,   32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    add_job(OPC_SIGNED,   32'h8000_0000, 32'h8000_0000, 0, 0);
    add_job(OPC_SIGNED,   32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    directed_cnt = job_q.size();

    // Random words; calm stretches send back to back, and the sender drains
    // the block fully before the random part and once midway.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm = ((i / 150) % 4 == 0);
      add_job($urandom_range(0, 1) ? OPC_SIGNED : OPC_UNSIGNED, pick_operand(),
              ($urandom_range(0, 19) == 0) ? '0 : pick_operand(), pick_idle(calm),
              (i == 0 || i == 800));
    end
    random_cnt = RANDOM_WORDS;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (job_q.size() != 0 || in_ch.valid || words_rcvd != words_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += quot_rem_q.size();

    $display("covered %0d words (%0d directed, %0d random): %0d signed, %0d divide by zero",
             directed_cnt + random_cnt, directed_cnt, random_cnt, signed_cnt, zero_div_cnt);
    $display("result channel held off %0d times for %0d cycles; %0d errors",
             holds_done, LONG_HOLD, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
